// ----- hdl/morse_key_timing_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Morse key timing decoder assertion macros
// Shared assertion wrappers. They compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef MORSE_KEY_TIMING_DECODER_MACROS_SVH
`define MORSE_KEY_TIMING_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside of reset
`define MKTD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("mktd check failed");

// Check that a condition implies a consequence in the same cycle
`define MKTD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mktd implication failed");

// Check that a condition implies a consequence in the next cycle
`define MKTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mktd sequence failed");

`else

`define MKTD_ASSERT(label, clk, rst, prop)
`define MKTD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MKTD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/mktd_pkg.sv -----
// ----------------------------------------------------------------------------
// Morse key timing decoder package
// Field widths, codes, shared types and the Morse code table.
// ----------------------------------------------------------------------------
package mktd_pkg;

   // Field widths
   localparam int TIME_W = 32;
   localparam int WPM_W  = 11;
   localparam int KIND_W = 2;
   localparam int CHAR_W = 7;

   // Unit length arithmetic
   localparam int UNIT_W = WPM_W;
   localparam int TWO_W  = UNIT_W + 1;
   localparam int FIVE_W = UNIT_W + 3;
   localparam logic [WPM_W-1:0]  UNIT_DIVIDEND = WPM_W'(1200);
   localparam logic [UNIT_W-1:0] UNIT_RESET    = UNIT_W'(60);

   localparam int MAX_ELEMENTS_DEFAULT = 8;

   // Code table geometry
   localparam int CODE_COUNT   = 36;
   localparam int CODE_LEN_W   = 3;
   localparam int CODE_PAT_W   = 5;
   localparam int CODE_MAX_LEN = 5;
   localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;

   typedef enum logic {
      OP_EDGE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE    = 2'd0,
      KIND_CHAR    = 2'd1,
      KIND_UNKNOWN = 2'd2,
      KIND_SPACE   = 2'd3
   } kind_type;

   typedef struct packed {
      logic              operation;
      logic              key_level;
      logic [TIME_W-1:0] time_ms;
   } item_type;

   typedef struct packed {
      kind_type          kind;
      logic [CHAR_W-1:0] character;
   } result_type;

   // Status of the unit length calculation
   typedef struct packed {
      logic              busy;
      logic [TWO_W-1:0]  two_unit;
      logic [FIVE_W-1:0] five_unit;
   } speed_status_type;

   typedef struct packed {
      logic              hit;
      logic [CHAR_W-1:0] character;
   } lookup_type;

   // Element count, dash pattern (bit i = element i) and ASCII of each code
   localparam logic [CODE_LEN_W-1:0] CODE_LEN [CODE_COUNT] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
      3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
      3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
   };

   localparam logic [CODE_PAT_W-1:0] CODE_PAT [CODE_COUNT] = '{
      5'h02, 5'h01, 5'h05, 5'h01, 5'h00, 5'h04, 5'h03, 5'h00, 5'h00, 5'h0E,
      5'h05, 5'h02, 5'h03, 5'h01, 5'h07, 5'h06, 5'h0B, 5'h02, 5'h00, 5'h01,
      5'h04, 5'h08, 5'h06, 5'h09, 5'h0D, 5'h03,
      5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F
   };

   localparam logic [CHAR_W-1:0] CODE_CHAR [CODE_COUNT] = '{
      7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A,
      7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54,
      7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39
   };

   // Match a length and the low pattern bits against the code table;
   // pattern bits at or above the length are masked off
   function automatic lookup_type code_lookup(input logic [CODE_LEN_W-1:0] len,
                                              input logic [CODE_PAT_W-1:0] pat);
      lookup_type            res;
      logic [CODE_PAT_W:0]   mask;
      logic [CODE_PAT_W-1:0] masked;
      mask = ((CODE_PAT_W+1)'(1) << len) - (CODE_PAT_W+1)'(1);
      masked = pat & mask[CODE_PAT_W-1:0];
      res.hit = 1'b0;
      res.character = '0;
      for (int i = 0; i < CODE_COUNT; i++) begin
         if (len == CODE_LEN[i] && masked == CODE_PAT[i]) begin
            res.hit = 1'b1;
            res.character = CODE_CHAR[i];
         end
      end
      return res;
   endfunction

endpackage

// ----- hdl/mktd_if.sv -----
// ----------------------------------------------------------------------------
// Morse key timing decoder channels
// Valid/ready channels for key items and decoded results.
// ----------------------------------------------------------------------------
interface mktd_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic                       key_level;
   logic [mktd_pkg::TIME_W-1:0] time_ms;

   modport source (output valid, operation, key_level, time_ms, input ready);
   modport sink   (input valid, operation, key_level, time_ms, output ready);
endinterface

interface mktd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mktd_pkg::KIND_W-1:0] event_kind;
   logic [mktd_pkg::CHAR_W-1:0] character;

   modport source (output valid, event_kind, character, input ready);
   modport sink   (input valid, event_kind, character, output ready);
endinterface

// ----- hdl/morse_key_timing_decoder.sv -----
// ----------------------------------------------------------------------------
// Morse key timing decoder
// Turns timestamped key edges and ticks into characters and word spaces.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one item per transfer: operation (edge or tick), key_level
//   and time_ms. rsp_ch returns exactly one result per item: event_kind and
//   character (0 for none and word space).
//   Each item is held in the input register and then decoded into the result
//   register, so rsp_ch.valid rises once the item has passed both registers.
//   One item is taken every cycle while the divider is idle and rsp_ch is not stalled.
//   A write on csr_write_enable/csr_write_data sets the speed; the unit length
//   comes out of a one-bit-per-cycle divider, so req_ch.ready stays low after
//   the write until the division is done.
//   Reset clears both registers and restores the speed to 20 words per
//   minute, with no clearing pass. When rsp_ch stalls, the result register
//   holds, the input register takes one more item and then req_ch.ready
//   drops until the result is taken.
// ----------------------------------------------------------------------------
`include "morse_key_timing_decoder_macros.svh"

module morse_key_timing_decoder #(
   parameter int MAX_ELEMENTS = mktd_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   mktd_req_if.sink                   req_ch,
   mktd_rsp_if.source                 rsp_ch,
   input  logic                       csr_write_enable,
   input  logic [mktd_pkg::WPM_W-1:0] csr_write_data
);

   mktd_pkg::speed_status_type speed;

   logic                 in_valid_ff, in_valid_in;
   mktd_pkg::item_type   in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   mktd_pkg::result_type out_result_ff;
   mktd_pkg::result_type result;
   logic                 req_fire;
   logic                 advance;

   // Speed register and unit length
   mktd_unit_div u_unit_div (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .write_data   (csr_write_data),
      .status       (speed)
   );

   // Key state and decode
   mktd_decode #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .speed   (speed),
      .result  (result)
   );

   // Handshake: advance when an item is held, the divider is idle and the result register is free or being emptied
   always_comb begin
      advance      = in_valid_ff && !speed.busy && (!out_valid_ff || rsp_ch.ready);
      req_ch.ready = !speed.busy && (!in_valid_ff || advance);
      req_fire     = req_ch.valid && req_ch.ready;
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the input transfer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.operation <= req_ch.operation;
         in_item_ff.key_level <= req_ch.key_level;
         in_item_ff.time_ms   <= req_ch.time_ms;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.event_kind = out_result_ff.kind;
   assign rsp_ch.character  = out_result_ff.character;

   `MKTD_ASSERT_IMPLY(a_busy_blocks, clock, reset, speed.busy, !req_ch.ready)
   `MKTD_ASSERT_IMPLY(a_blank_char, clock, reset,
      rsp_ch.valid && (rsp_ch.event_kind == mktd_pkg::KIND_NONE ||
                       rsp_ch.event_kind == mktd_pkg::KIND_SPACE),
      rsp_ch.character == '0)

endmodule

// ----- hdl/mktd_unit_div.sv -----
// ----------------------------------------------------------------------------
// Unit length divider
// Restoring divider that forms 1200 / wpm one quotient bit per cycle and
// keeps the two-unit and five-unit thresholds.
// ----------------------------------------------------------------------------
`include "morse_key_timing_decoder_macros.svh"

module mktd_unit_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          write_enable,
   input  logic [mktd_pkg::WPM_W-1:0]    write_data,
   output mktd_pkg::speed_status_type    status
);

   localparam int DIV_W = mktd_pkg::WPM_W;
   localparam int CNT_W = $clog2(DIV_W + 1);

   logic                        busy_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [DIV_W-1:0]            divisor_ff;
   logic [DIV_W-1:0]            rem_ff;
   logic [DIV_W-1:0]            quo_ff;
   logic [mktd_pkg::TWO_W-1:0]  two_ff;
   logic [mktd_pkg::FIVE_W-1:0] five_ff;

   logic [DIV_W:0]              rem_shift;
   logic [DIV_W:0]              rem_sub;
   logic                        fits;
   logic [DIV_W-1:0]            rem_in;
   logic [DIV_W-1:0]            quo_in;
   logic [mktd_pkg::UNIT_W-1:0] unit;
   logic [mktd_pkg::TWO_W-1:0]  two_in;
   logic [mktd_pkg::FIVE_W-1:0] five_in;
   logic                        last_step;

   // One restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      rem_sub   = rem_shift - {1'b0, divisor_ff};
      fits      = rem_shift >= {1'b0, divisor_ff};
      rem_in    = fits ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
      quo_in    = {quo_ff[DIV_W-2:0], fits};
      unit      = (quo_in == '0) ? mktd_pkg::UNIT_W'(1) : quo_in;
      two_in    = {unit, 1'b0};
      five_in   = mktd_pkg::FIVE_W'({unit, 2'b00}) + mktd_pkg::FIVE_W'(unit);
      last_step = busy_ff && (cnt_ff == CNT_W'(1));
   end

   // Sequence control and thresholds
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         two_ff  <= {mktd_pkg::UNIT_RESET, 1'b0};
         five_ff <= mktd_pkg::FIVE_W'({mktd_pkg::UNIT_RESET, 2'b00})
                    + mktd_pkg::FIVE_W'(mktd_pkg::UNIT_RESET);
      end else if (write_enable) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DIV_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (last_step) begin
            busy_ff <= 1'b0;
            two_ff  <= two_in;
            five_ff <= five_in;
         end
      end
   end

   // Divider datapath; a zero speed divides by one
   always_ff @(posedge clock) begin
      if (write_enable) begin
         divisor_ff <= (write_data == '0) ? DIV_W'(1) : write_data;
         rem_ff     <= '0;
         quo_ff     <= mktd_pkg::UNIT_DIVIDEND;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign status.busy      = busy_ff;
   assign status.two_unit  = two_ff;
   assign status.five_unit = five_ff;

   `MKTD_ASSERT_NEXT(a_write_starts, clock, reset, write_enable, busy_ff)
   `MKTD_ASSERT_NEXT(a_last_step_done, clock, reset, last_step && !write_enable, !busy_ff)

endmodule

// ----- hdl/mktd_decode.sv -----
// ----------------------------------------------------------------------------
// Morse key element decoder
// Keeps the key timing state, classifies presses and flushes characters.
// ----------------------------------------------------------------------------
`include "morse_key_timing_decoder_macros.svh"

module mktd_decode #(
   parameter int MAX_ELEMENTS = mktd_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  mktd_pkg::item_type         item,
   input  mktd_pkg::speed_status_type speed,
   output mktd_pkg::result_type       result
);

   localparam int TOTAL_W = $clog2(MAX_ELEMENTS + 1);
   localparam int IDX_W   = $clog2(MAX_ELEMENTS);

   logic                          started_ff, started_in;
   logic                          level_ff, level_in;
   logic                          space_ff, space_in;
   logic [mktd_pkg::TIME_W-1:0]   last_time_ff, last_time_in;
   logic [TOTAL_W-1:0]            total_ff, total_in;
   logic [MAX_ELEMENTS-1:0]       bits_ff, bits_in;

   logic [mktd_pkg::TIME_W-1:0]   dur;
   logic                          gap_two, press_long, gap_five;
   logic [mktd_pkg::CODE_LEN_W-1:0] len_sel;
   mktd_pkg::lookup_type          code;
   mktd_pkg::result_type          flush_res;

   // Durations and code lookup
   always_comb begin
      dur        = item.time_ms - last_time_ff;
      gap_two    = dur >= mktd_pkg::TIME_W'(speed.two_unit);
      press_long = dur >  mktd_pkg::TIME_W'(speed.two_unit);
      gap_five   = dur >= mktd_pkg::TIME_W'(speed.five_unit);
      len_sel    = (total_ff <= TOTAL_W'(mktd_pkg::CODE_MAX_LEN)) ?
                   total_ff[mktd_pkg::CODE_LEN_W-1:0] : '0;
      code       = mktd_pkg::code_lookup(len_sel, bits_ff[mktd_pkg::CODE_PAT_W-1:0]);
      if (code.hit) begin
         flush_res.kind      = mktd_pkg::KIND_CHAR;
         flush_res.character = code.character;
      end else begin
         flush_res.kind      = mktd_pkg::KIND_UNKNOWN;
         flush_res.character = mktd_pkg::CHAR_UNKNOWN;
      end
   end

   // Next state and result for the item
   always_comb begin
      started_in       = started_ff;
      level_in         = level_ff;
      space_in         = space_ff;
      last_time_in     = last_time_ff;
      total_in         = total_ff;
      bits_in          = bits_ff;
      result.kind      = mktd_pkg::KIND_NONE;
      result.character = '0;
      if (item.operation == mktd_pkg::OP_EDGE) begin
         if (!started_ff) begin
            started_in   = 1'b1;
            level_in     = item.key_level;
            last_time_in = item.time_ms;
         end else if (item.key_level != level_ff) begin
            if (item.key_level) begin
               // press: a long enough gap ends the character
               if (total_ff != '0 && gap_two) begin
                  result   = flush_res;
                  total_in = '0;
               end
               space_in = 1'b0;
            end else if (total_ff < TOTAL_W'(MAX_ELEMENTS)) begin
               // release: store a dot or a dash
               bits_in[total_ff[IDX_W-1:0]] = press_long;
               total_in = total_ff + TOTAL_W'(1);
            end
            level_in     = item.key_level;
            last_time_in = item.time_ms;
         end
      end else if (started_ff && !level_ff) begin
         if (total_ff != '0) begin
            if (gap_two) begin
               result   = flush_res;
               total_in = '0;
               space_in = 1'b0;
            end
         end else if (!space_ff && gap_five) begin
            space_in    = 1'b1;
            result.kind = mktd_pkg::KIND_SPACE;
         end
      end
   end

   // Hold state between items
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         level_ff     <= 1'b0;
         space_ff     <= 1'b1;
         last_time_ff <= '0;
         total_ff     <= '0;
      end else if (advance) begin
         started_ff   <= started_in;
         level_ff     <= level_in;
         space_ff     <= space_in;
         last_time_ff <= last_time_in;
         total_ff     <= total_in;
      end
   end

   // Element bits are only read below the element count
   always_ff @(posedge clock) begin
      if (advance) begin
         bits_ff <= bits_in;
      end
   end

   `MKTD_ASSERT(a_total_bound, clock, reset, total_ff <= TOTAL_W'(MAX_ELEMENTS))

endmodule
